// ----- hw/rtl/averaging_thermostat_assert.svh -----
// Assertion macros shared by the averaging thermostat RTL.
`ifndef AVERAGING_THERMOSTAT_ASSERT_SVH
`define AVERAGING_THERMOSTAT_ASSERT_SVH

`ifndef SYNTHESIS
// Checks a property at every clock edge outside reset.
`define AVGT_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("averaging thermostat assertion failed");
// Checks that a condition implies another one on the following edge.
`define AVGT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("averaging thermostat assertion failed");
`else
`define AVGT_ASSERT(label, clk, rst_n, prop)
`define AVGT_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif

`endif

// ----- hw/rtl/avgt_pkg.sv -----
// Types, constants and register codes of the averaging thermostat.
package avgt_pkg;

	localparam int RING_DEPTH_DEF = 10;
	localparam int QUEUE_DEPTH    = 2;

	localparam int ADC_W    = 10;
	localparam int TEMP_W   = 9;
	localparam int SETPT_W  = 7;
	localparam int STEP_W   = 4;
	localparam int DBAND_W  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 2'd3;

	localparam logic [SETPT_W-1:0] LOW_LIMIT_RST  = 7'd35;
	localparam logic [SETPT_W-1:0] HIGH_LIMIT_RST = 7'd75;
	localparam logic [STEP_W-1:0]  STEP_RST       = 4'd5;
	localparam logic [DBAND_W-1:0] DEADBAND_RST   = 5'd5;
	localparam logic [SETPT_W-1:0] SETPOINT_RST   = 7'd50;
	localparam logic [SETPT_W-1:0] SETPOINT_MAX   = 7'd127;

	typedef enum logic [1:0] {
		OP_SAMPLE  = 2'd0,
		OP_UP      = 2'd1,
		OP_DOWN    = 2'd2,
		OP_REFRESH = 2'd3
	} op_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_FIX,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		logic [1:0]       operation;
		logic [ADC_W-1:0] adc_sample;
		logic             blink_phase;
	} in_item_t;

	typedef struct packed {
		logic              heater_on;
		logic              cooler_on;
		logic              lamp_on;
		logic [TEMP_W-1:0] shown_value;
		logic [TEMP_W-1:0] average_temp;
	} out_item_t;

	// A classified request as it waits in the queue.
	typedef struct packed {
		op_kind_t          kind;
		logic [TEMP_W-1:0] temp;
		logic              phase;
	} cmd_t;

	typedef struct packed {
		logic [SETPT_W-1:0] low_limit;
		logic [SETPT_W-1:0] high_limit;
		logic [STEP_W-1:0]  step;
		logic [DBAND_W-1:0] deadband;
	} cfg_t;

endpackage

// ----- hw/rtl/averaging_thermostat.sv -----
// Top level of the averaging thermostat: configuration registers and the front, queue and back.
// The averaging thermostat takes one request at a time through in_valid/in_ready and returns
// exactly one result per request through out_valid/out_ready. A sample request halves the ten-bit
// converter reading into a temperature, writes it into a ring of RING_DEPTH entries (the first
// sample after reset fills every entry), recomputes the truncated average of the ring and decides
// heater, cooler and lamp from the deadband around the setpoint. A refresh request repeats the
// decision without touching the ring, and up and down requests step the setpoint only while it lies
// inside its limits and report all drives off. In the back end a sample request is popped and
// written to the ring (ST_IDLE), the single adder walks the ring (ST_SUM), the reciprocal multiply
// runs (ST_MUL), the divide is corrected (ST_FIX) and the result register is loaded (ST_EMIT) once
// no earlier result waits. Button and refresh requests go from ST_IDLE straight to ST_EMIT. A
// two-entry queue separates the front from the back, so requests are still accepted while a result
// waits to be taken. Configuration registers are to be written through cfg_we, cfg_index and cfg_wdata
// only while the block is idle (the block itself does not enforce this), and take effect on the next request.
module averaging_thermostat #(
	parameter int RING_DEPTH = avgt_pkg::RING_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  avgt_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output avgt_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [avgt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [avgt_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	avgt_pkg::cfg_t cfg_q;
	avgt_pkg::cmd_t front_cmd;
	avgt_pkg::cmd_t queue_head;
	logic           queue_full;
	logic           queue_empty;
	logic           queue_push;
	logic           queue_pop;

	// Configuration register file; every write lands at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_limit  <= avgt_pkg::LOW_LIMIT_RST;
			cfg_q.high_limit <= avgt_pkg::HIGH_LIMIT_RST;
			cfg_q.step       <= avgt_pkg::STEP_RST;
			cfg_q.deadband   <= avgt_pkg::DEADBAND_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				avgt_pkg::CFG_LOW_LIMIT:  cfg_q.low_limit  <= cfg_wdata;
				avgt_pkg::CFG_HIGH_LIMIT: cfg_q.high_limit <= cfg_wdata;
				avgt_pkg::CFG_STEP:       cfg_q.step       <= cfg_wdata[avgt_pkg::STEP_W-1:0];
				avgt_pkg::CFG_DEADBAND:   cfg_q.deadband   <= cfg_wdata[avgt_pkg::DBAND_W-1:0];
				default: ;
			endcase
		end
	end

	// The front end decodes each request and hands it to the queue.
	avgt_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (queue_full),
		.q_push   (queue_push),
		.q_data   (front_cmd)
	);

	// The queue lets the front keep accepting while the back end is busy.
	avgt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (queue_push),
		.push_data (front_cmd),
		.full      (queue_full),
		.pop       (queue_pop),
		.empty     (queue_empty),
		.head      (queue_head)
	);

	// The back end owns the ring, the average, the setpoint and the result register.
	avgt_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (queue_empty),
		.q_head    (queue_head),
		.q_pop     (queue_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- hw/rtl/avgt_front.sv -----
// Front end: accepts requests and classifies them into queue commands.
module avgt_front (
	input  logic             in_valid,
	output logic             in_ready,
	input  avgt_pkg::in_item_t in_data,
	input  logic             q_full,
	output logic             q_push,
	output avgt_pkg::cmd_t   q_data
);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_data.phase = in_data.blink_phase;
		// The converter reading is halved to give the temperature.
		q_data.temp  = in_data.adc_sample[avgt_pkg::ADC_W-1:1];
		case (in_data.operation)
			avgt_pkg::OP_SAMPLE:  q_data.kind = avgt_pkg::OP_SAMPLE;
			avgt_pkg::OP_UP:      q_data.kind = avgt_pkg::OP_UP;
			avgt_pkg::OP_DOWN:    q_data.kind = avgt_pkg::OP_DOWN;
			default:              q_data.kind = avgt_pkg::OP_REFRESH;
		endcase
	end

endmodule

// ----- hw/rtl/avgt_queue.sv -----
// Short command queue between the front end and the back end.
module avgt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  avgt_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output avgt_pkg::cmd_t head
);

	localparam int DEPTH = avgt_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	avgt_pkg::cmd_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/avgt_back.sv -----
// Back end: ring of temperatures, averaging, setpoint and drive decision.
module avgt_back #(
	parameter int RING_DEPTH = avgt_pkg::RING_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  avgt_pkg::cfg_t      cfg,
	input  logic                q_empty,
	input  avgt_pkg::cmd_t      q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output avgt_pkg::out_item_t out_data
);

	`include "averaging_thermostat_assert.svh"

	localparam int TW    = avgt_pkg::TEMP_W;
	localparam int SW    = avgt_pkg::SETPT_W;
	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int SUM_W = TW + $clog2(RING_DEPTH);
	localparam int PROD_W = 2 * SUM_W;
	// Floor of 2^SUM_W / depth: the estimate is short by at most one.
	localparam int RECIP = (2 ** SUM_W) / RING_DEPTH;
	localparam logic [SUM_W-1:0] RECIP_C = SUM_W'(RECIP);
	localparam logic [SUM_W-1:0] DEPTH_C = SUM_W'(RING_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
	localparam int CMP_W = 11;

	avgt_pkg::back_state_t state_q, state_d;

	logic [TW-1:0]     ring_q [RING_DEPTH];
	logic [IDX_W-1:0]  ring_pos_q;
	logic              ring_primed_q;
	logic [IDX_W-1:0]  sum_idx_q;
	logic [SUM_W-1:0]  acc_q;
	logic [PROD_W-1:0] prod_s1;
	logic [TW-1:0]     average_q;
	logic [TW-1:0]     latest_q;
	logic [SW-1:0]     setpoint_q;
	avgt_pkg::cmd_t    cmd_q;
	logic              out_valid_q;
	avgt_pkg::out_item_t out_q;

	logic              pop_go;
	logic              sum_go;
	logic              mul_go;
	logic              fix_go;
	logic              emit_go;

	logic [SUM_W-1:0]  quot_est;
	logic [PROD_W-1:0] back_prod;
	logic [SUM_W-1:0]  remainder;
	logic [SUM_W-1:0]  quot_fix;
	logic [SW:0]       sp_up;
	logic [SW-1:0]     sp_next;
	logic signed [CMP_W-1:0] s_val, a_minus_d, a_plus_d;
	logic              cool, heat;
	avgt_pkg::out_item_t out_next;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			avgt_pkg::ST_IDLE: begin
				if (!q_empty) begin
					state_d = (q_head.kind == avgt_pkg::OP_SAMPLE) ?
						avgt_pkg::ST_SUM : avgt_pkg::ST_EMIT;
				end
			end
			avgt_pkg::ST_SUM: begin
				if (sum_idx_q == LAST_IDX) begin
					state_d = avgt_pkg::ST_MUL;
				end
			end
			avgt_pkg::ST_MUL: state_d = avgt_pkg::ST_FIX;
			avgt_pkg::ST_FIX: state_d = avgt_pkg::ST_EMIT;
			avgt_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = avgt_pkg::ST_IDLE;
				end
			end
			default: state_d = avgt_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		pop_go  = 1'b0;
		sum_go  = 1'b0;
		mul_go  = 1'b0;
		fix_go  = 1'b0;
		emit_go = 1'b0;
		case (state_q)
			avgt_pkg::ST_IDLE: pop_go  = !q_empty;
			avgt_pkg::ST_SUM:  sum_go  = 1'b1;
			avgt_pkg::ST_MUL:  mul_go  = 1'b1;
			avgt_pkg::ST_FIX:  fix_go  = 1'b1;
			avgt_pkg::ST_EMIT: emit_go = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign q_pop = pop_go;

	// Average correction: the reciprocal estimate is raised by one if short.
	always_comb begin
		quot_est  = prod_s1[PROD_W-1:SUM_W];
		back_prod = {{SUM_W{1'b0}}, quot_est} * {{SUM_W{1'b0}}, DEPTH_C};
		remainder = acc_q - back_prod[SUM_W-1:0];
		quot_fix  = (remainder >= DEPTH_C) ? quot_est + 1'b1 : quot_est;
	end

	// Setpoint stepping with saturation.
	always_comb begin
		sp_up   = {1'b0, setpoint_q} + {{(SW - avgt_pkg::STEP_W + 1){1'b0}}, cfg.step};
		sp_next = setpoint_q;
		case (cmd_q.kind)
			avgt_pkg::OP_UP: begin
				if (setpoint_q < cfg.high_limit) begin
					sp_next = sp_up[SW] ? avgt_pkg::SETPOINT_MAX : sp_up[SW-1:0];
				end
			end
			avgt_pkg::OP_DOWN: begin
				if (setpoint_q > cfg.low_limit) begin
					sp_next = (setpoint_q >= SW'(cfg.step)) ?
						setpoint_q - SW'(cfg.step) : '0;
				end
			end
			default: ;
		endcase
	end

	// Deadband decision in signed arithmetic.
	always_comb begin
		s_val     = $signed({{(CMP_W - SW){1'b0}}, setpoint_q});
		a_minus_d = $signed({{(CMP_W - TW){1'b0}}, average_q})
			- $signed({{(CMP_W - avgt_pkg::DBAND_W){1'b0}}, cfg.deadband});
		a_plus_d  = $signed({{(CMP_W - TW){1'b0}}, average_q})
			+ $signed({{(CMP_W - avgt_pkg::DBAND_W){1'b0}}, cfg.deadband});
		cool = (s_val <= a_minus_d) && (s_val < a_plus_d);
		heat = (s_val >= a_plus_d) && (s_val > a_minus_d);
	end

	always_comb begin
		out_next.average_temp = average_q;
		if (cmd_q.kind == avgt_pkg::OP_UP || cmd_q.kind == avgt_pkg::OP_DOWN) begin
			out_next.heater_on   = 1'b0;
			out_next.cooler_on   = 1'b0;
			out_next.lamp_on     = 1'b0;
			out_next.shown_value = {{(TW - SW){1'b0}}, sp_next};
		end else begin
			out_next.heater_on   = heat;
			out_next.cooler_on   = cool;
			out_next.lamp_on     = cool || (heat && cmd_q.phase);
			out_next.shown_value = latest_q;
		end
	end

	// Ring and datapath registers that need no reset.
	always_ff @(posedge clk) begin
		if (pop_go) begin
			cmd_q <= q_head;
			if (q_head.kind == avgt_pkg::OP_SAMPLE) begin
				if (!ring_primed_q) begin
					for (int i = 0; i < RING_DEPTH; i++) begin
						ring_q[i] <= q_head.temp;
					end
				end else begin
					ring_q[ring_pos_q] <= q_head.temp;
				end
			end
		end
		if (pop_go) begin
			acc_q <= '0;
		end else if (sum_go) begin
			acc_q <= acc_q + {{(SUM_W - TW){1'b0}}, ring_q[sum_idx_q]};
		end
		if (mul_go) begin
			prod_s1 <= {{SUM_W{1'b0}}, acc_q} * {{SUM_W{1'b0}}, RECIP_C};
		end
		if (emit_go) begin
			out_q <= out_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= avgt_pkg::ST_IDLE;
			ring_pos_q    <= '0;
			ring_primed_q <= 1'b0;
			sum_idx_q     <= '0;
			average_q     <= '0;
			latest_q      <= '0;
			setpoint_q    <= avgt_pkg::SETPOINT_RST;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop_go && q_head.kind == avgt_pkg::OP_SAMPLE) begin
				latest_q      <= q_head.temp;
				ring_primed_q <= 1'b1;
				if (ring_primed_q) begin
					ring_pos_q <= (ring_pos_q == LAST_IDX) ? '0 : ring_pos_q + 1'b1;
				end
			end
			// The sum index wraps after the last entry so it never leaves the ring.
			if (pop_go) begin
				sum_idx_q <= '0;
			end else if (sum_go) begin
				sum_idx_q <= (sum_idx_q == LAST_IDX) ? '0 : sum_idx_q + 1'b1;
			end
			if (fix_go) begin
				average_q <= quot_fix[TW-1:0];
			end
			if (emit_go) begin
				setpoint_q <= sp_next;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`AVGT_ASSERT(a_pos_in_range, clk, arst_n, ring_pos_q <= LAST_IDX)
	`AVGT_ASSERT(a_idx_in_range, clk, arst_n, sum_idx_q <= LAST_IDX)
	`AVGT_ASSERT(a_drives_exclusive, clk, arst_n, !(out_valid_q && out_q.heater_on && out_q.cooler_on))
	`AVGT_ASSERT_NEXT(a_result_from_emit, clk, arst_n, state_q != avgt_pkg::ST_EMIT && !out_valid_q, !out_valid_q)

endmodule
